>>> rtl/core/md5_pkg.sv
package md5_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        final_word;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  function automatic logic [31:0] sine_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/md5_round.sv
module md5_round (
  input  logic [5:0]  round_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  output logic [31:0] b_o
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] dbl;

  always_comb begin
    case (round_i[5:4])
      2'd0:    f = (b_i & c_i) | (~b_i & d_i);
      2'd1:    f = (d_i & b_i) | (~d_i & c_i);
      2'd2:    f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
    t   = a_i + f + sine_k(round_i) + m_i;
    dbl = {t, t} << rot_s(round_i);
    b_o = b_i + dbl[63:32];
  end

endmodule

>>> rtl/core/md5_hash_stream.sv
// Streaming MD5 digest engine.
// The input channel carries one message word per transfer: bytes in little
// endian order, valid_bytes giving how many low bytes count (values above 4
// count as 4, and any word, not only the final one, may carry fewer),
// final_word marking the message end. The output channel delivers four
// transfers per message, digest words A, B, C and D, with last_word set on D.
// Words are packed one byte per cycle into a 16-word buffer. A full 64-byte
// block then runs through one shared round unit, one round per cycle, while
// byte packing and padding pause.
// A final word adds the 0x80 marker, zero padding and the 64-bit bit length
// one byte per cycle, up to two more blocks, then the four digest transfers.
// The block is not ready while it works on a word or holds a digest.
// When the receiver stalls, the current digest word simply holds.
// Reset restores the MD5 initial chaining values and clears all counters;
// after a digest is taken the block returns to that state for a new message.
module md5_hash_stream (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  md5_pkg::md5_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output md5_pkg::md5_out_t   out_data_o
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BYTES, ST_PAD, ST_LEN, ST_ROUND, ST_OUT
  } state_e;

  state_e      state_q;
  state_e      ret_q;
  logic [31:0] chain_q [4];
  logic [31:0] buf_q [16];
  logic [31:0] work_q [4];
  logic [60:0] msg_q;
  logic [5:0]  fill_q;
  logic [5:0]  round_q;
  logic [31:0] data_q;
  logic [2:0]  cnt_q;
  logic        fin_q;
  logic [2:0]  lpos_q;
  logic [63:0] bitlen_q;
  logic [1:0]  oidx_q;

  logic [3:0]  g;
  logic [31:0] new_b;
  logic [7:0]  pbyte;
  logic        push;

  always_comb begin
    case (round_q[5:4])
      2'd0:    g = round_q[3:0];
      2'd1:    g = 4'(5 * round_q + 1);
      2'd2:    g = 4'(3 * round_q + 5);
      default: g = 4'(7 * round_q);
    endcase
  end

  md5_round u_round (
    .round_i(round_q), .a_i(work_q[0]), .b_i(work_q[1]), .c_i(work_q[2]),
    .d_i(work_q[3]), .m_i(buf_q[g]), .b_o(new_b)
  );

  always_comb begin
    push  = 1'b0;
    pbyte = data_q[7:0];
    case (state_q)
      ST_BYTES: push = (cnt_q != 3'd0);
      ST_PAD: begin
        push  = 1'b1;
        pbyte = 8'h00;
      end
      ST_LEN: begin
        push  = 1'b1;
        pbyte = bitlen_q[7:0];
      end
      default: push = 1'b0;
    endcase
  end

  // Byte lane writes into the block buffer.
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= pbyte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      chain_q  <= '{IV_A, IV_B, IV_C, IV_D};
      work_q   <= '{default: '0};
      msg_q    <= '0;
      fill_q   <= '0;
      round_q  <= '0;
      data_q   <= '0;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      lpos_q   <= '0;
      bitlen_q <= '0;
      oidx_q   <= '0;
    end else begin
      if (push) begin
        fill_q <= fill_q + 6'd1;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            data_q  <= in_data_i.data_word;
            cnt_q   <= (in_data_i.valid_bytes > 3'd4) ? 3'd4 : in_data_i.valid_bytes;
            fin_q   <= in_data_i.final_word;
            state_q <= ST_BYTES;
          end
        end
        ST_BYTES: begin
          if (cnt_q != 3'd0) begin
            data_q <= data_q >> 8;
            cnt_q  <= cnt_q - 3'd1;
            msg_q  <= msg_q + 61'd1;
            ret_q  <= ST_BYTES;
            if (fill_q == 6'd63) begin
              work_q  <= chain_q;
              state_q <= ST_ROUND;
            end
          end else if (fin_q) begin
            // Marker byte goes in through the data lane.
            data_q   <= {24'd0, PAD_BYTE};
            cnt_q    <= 3'd1;
            fin_q    <= 1'b0;
            bitlen_q <= {msg_q, 3'b000};
            lpos_q   <= '0;
            ret_q    <= ST_PAD;
            // Pad or length path is entered once the marker byte has been pushed.
            state_q  <= ST_BYTES;
            msg_q    <= msg_q - 61'd1;
            oidx_q   <= 2'd1;
          end else if (oidx_q == 2'd1) begin
            oidx_q  <= 2'd0;
            state_q <= (fill_q == LEN_POS) ? ST_LEN : ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_PAD: begin
          ret_q <= ST_PAD;
          if (fill_q == 6'd63) begin
            work_q  <= chain_q;
            state_q <= ST_ROUND;
          end else if (fill_q + 6'd1 == LEN_POS) begin
            state_q <= ST_LEN;
          end
        end
        ST_LEN: begin
          bitlen_q <= bitlen_q >> 8;
          lpos_q   <= lpos_q + 3'd1;
          if (lpos_q == 3'd7) begin
            ret_q   <= ST_OUT;
            work_q  <= chain_q;
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          work_q  <= '{work_q[3], new_b, work_q[1], work_q[2]};
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) begin
            chain_q[0] <= chain_q[0] + work_q[3];
            chain_q[1] <= chain_q[1] + new_b;
            chain_q[2] <= chain_q[2] + work_q[1];
            chain_q[3] <= chain_q[3] + work_q[2];
            state_q    <= ret_q;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 2'd1;
            if (oidx_q == 2'd3) begin
              chain_q <= '{IV_A, IV_B, IV_C, IV_D};
              msg_q   <= '0;
              fill_q  <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o             = (state_q == ST_IDLE);
  assign out_valid_o            = (state_q == ST_OUT);
  assign out_data_o.digest_word = chain_q[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.last_word   = (oidx_q == 2'd3);

endmodule

>>> tb/tb_md5_hash_stream.sv
`timescale 1ns / 100ps

module tb_md5_hash_stream;
  import md5_pkg::*;

  // The digest model. It keeps the chaining words, the block buffer, the fill
  // position and the byte count, and it runs the 64 rounds of a block in plain
  // SystemVerilog whenever the buffer fills up.
  class md5_scoreboard;
    logic [31:0] chain[4];
    logic [31:0] blk[16];
    logic [60:0] msg_len;
    logic [5:0]  fill;
    md5_out_t    pending_digest[$];
    int          mismatches;
    int          digests_seen;

    function void restart();
      chain[0] = IV_A;
      chain[1] = IV_B;
      chain[2] = IV_C;
      chain[3] = IV_D;
      msg_len = '0;
      fill = '0;
    endfunction

    function void run_rounds();
      logic [31:0] a, b, c, d, f, t, sum, tmp_d;
      logic [3:0]  g;
      logic [4:0]  s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          f = (b & c) | (~b & d);
          g = 4'(r);
        end else if (r < 32) begin
          f = (d & b) | (~d & c);
          g = 4'(5 * r + 1);
        end else if (r < 48) begin
          f = b ^ c ^ d;
          g = 4'(3 * r + 5);
        end else begin
          f = c ^ (b | ~d);
          g = 4'(7 * r);
        end
        t = a + f + sine_k(6'(r)) + blk[g];
        s = rot_s(6'(r));
        sum = (t << s) | (t >> (32 - s));
        tmp_d = d;
        d = c;
        c = b;
        b = b + sum;
        a = tmp_d;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void add_byte(logic [7:0] v);
      blk[fill[5:2]][fill[1:0]*8 +: 8] = v;
      fill++;
      if (fill == 0) run_rounds();
    endfunction

    // Note one accepted input word and queue the digest when it ends a message.
    function void note_word(md5_in_t w);
      int n;
      logic [63:0] bits;
      md5_out_t o;
      n = (w.valid_bytes > 4) ? 4 : w.valid_bytes;
      for (int i = 0; i < n; i++) begin
        add_byte(w.data_word[8*i +: 8]);
        msg_len++;
      end
      if (!w.final_word) return;
      bits = {msg_len, 3'b000};
      add_byte(PAD_BYTE);
      while (fill != LEN_POS) add_byte(8'h00);
      for (int i = 0; i < 8; i++) add_byte(bits[8*i +: 8]);
      for (int i = 0; i < 4; i++) begin
        o.digest_word = chain[i];
        o.word_index = 2'(i);
        o.last_word = (i == 3);
        pending_digest.push_back(o);
      end
      restart();
    endfunction

    function void check_digest(md5_out_t got);
      md5_out_t exp;
      if (pending_digest.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest transfer %h", got);
        return;
      end
      exp = pending_digest.pop_front();
      digests_seen++;
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: expected word %h idx %0d last %0b, got %h idx %0d last %0b",
                   exp.digest_word, exp.word_index, exp.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  md5_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  md5_out_t out_data_o;

  md5_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;
  int words_sent;
  int messages_sent;

  md5_hash_stream i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // The receiver side: ready is redrawn on every rising edge, and every accepted
  // digest transfer is checked against the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_digest(out_data_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The watchdog counts cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d cycles without a transfer", idle_cycles);
      $display("[md5_hash_stream] ERROR");
      $finish;
    end
  end

  // Send one word: an optional random gap, then hold valid until the transfer.
  // Valid stays high after the transfer; the next word or gap drives it again.
  task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                           input logic fin);
    md5_in_t w;
    w.data_word = data;
    w.valid_bytes = nbytes;
    w.final_word = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    words_sent++;
    if (fin) messages_sent++;
  endtask

  // A whole message of random content. Mostly full words; a few short
  // non-final words keep the byte stream unaligned.
  task automatic send_message(input int nwords);
    logic [2:0] nb;
    for (int i = 0; i < nwords - 1; i++) begin
      nb = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
      send_word($urandom, nb, 1'b0);
    end
    send_word($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  task automatic run_random(input int nwords);
    int target;
    int len;
    target = words_sent + nwords;
    while (words_sent < target) begin
      case ($urandom_range(3))
        0: len = $urandom_range(1, 3);
        1: len = $urandom_range(13, 18);
        default: len = $urandom_range(1, 40);
      endcase
      send_message(len);
    end
  endtask

  initial begin
    sb = new();
    sb.restart();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the empty message, all-zero and all-one words, every
    // byte count on a final word, byte counts above four, and short
    // non-final words that leave the buffer unaligned.
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    for (int n = 1; n <= 7; n++) send_word(32'h6463_6261, 3'(n), 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_word(32'hA5A5_5A5A, 3'd3, 1'b0);
    send_word(32'h1234_5678, 3'd7, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
    // Fifty-five bytes fit one block with padding; fifty-six spill into a second.
    for (int i = 0; i < 13; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);
    for (int i = 0; i < 14; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd0, 1'b1);

    // Random messages under the three idling patterns.
    send_idle_pct = 33;
    recv_idle_pct = 59;
    run_random(150);
    send_idle_pct = 59;
    recv_idle_pct = 33;
    run_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(150);
    in_valid_i <= 1'b0;

    while (sb.pending_digest.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d words in %0d messages; %0d digest words checked.",
             words_sent, messages_sent, sb.digests_seen);
    if (sb.mismatches == 0 && sb.pending_digest.size() == 0) begin
      $display("[md5_hash_stream] OK");
    end else begin
      $display("%0d mismatches, %0d digest words still pending",
               sb.mismatches, sb.pending_digest.size());
      $display("[md5_hash_stream] ERROR");
    end
    $finish;
  end

endmodule
